// ----- rtl/core/pss_pkg.sv -----
`timescale 1ns / 1ps

package pss_pkg;

	localparam int unsigned PeriodW = 12;
	localparam int unsigned VolW    = 4;
	localparam int unsigned SawLvlW = 5;
	localparam int unsigned MixW    = 6;
	localparam int unsigned ShiftW  = 4;
	localparam int unsigned DivW    = 16;

	localparam logic [15:0] AddrMask    = 16'hF003;
	localparam logic [15:0] AddrP0Ctrl  = 16'h9000;
	localparam logic [15:0] AddrP0Lo    = 16'h9001;
	localparam logic [15:0] AddrP0Hi    = 16'h9002;
	localparam logic [15:0] AddrHalt    = 16'h9003;
	localparam logic [15:0] AddrP1Ctrl  = 16'hA000;
	localparam logic [15:0] AddrP1Lo    = 16'hA001;
	localparam logic [15:0] AddrP1Hi    = 16'hA002;
	localparam logic [15:0] AddrSawRate = 16'hB000;
	localparam logic [15:0] AddrSawLo   = 16'hB001;
	localparam logic [15:0] AddrSawHi   = 16'hB002;

	localparam logic [DivW-1:0] DividerReset = 16'd40;
	localparam logic [3:0]      SawLastPhase = 4'd13;

	typedef struct packed {
		logic       ctrl_we;
		logic       lo_we;
		logic       hi_we;
		logic [7:0] data;
	} pss_wr_t;

endpackage

// ----- rtl/core/pss_pulse.sv -----
`timescale 1ns / 1ps

module pss_pulse (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           tick,
	input  pss_pkg::pss_wr_t               wr,
	input  logic [pss_pkg::ShiftW-1:0]     shift,
	output logic [pss_pkg::VolW-1:0]       level_nxt
);
	import pss_pkg::*;

	logic [PeriodW-1:0] period_q, cnt_q, cnt_d;
	logic [VolW-1:0]    vol_q, lvl_q, lvl_d;
	logic [2:0]         duty_q;
	logic               dc_q, en_q;
	logic [3:0]         step_q, step_d;

	always_comb begin
		cnt_d  = cnt_q;
		step_d = step_q;
		lvl_d  = lvl_q;
		if (tick) begin
			if (!en_q) begin
				lvl_d  = '0;
				step_d = 4'hF;
			end else begin
				if (cnt_q == '0) begin
					cnt_d  = period_q >> shift;
					step_d = step_q - 4'd1;
				end else begin
					cnt_d = cnt_q - 12'd1;
				end
				lvl_d = (dc_q || (step_d <= {1'b0, duty_q})) ? vol_q : '0;
			end
		end
	end

	assign level_nxt = lvl_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			period_q <= '0;
			cnt_q    <= '0;
			vol_q    <= '0;
			duty_q   <= '0;
			dc_q     <= 1'b0;
			en_q     <= 1'b0;
			step_q   <= '0;
			lvl_q    <= '0;
		end else begin
			cnt_q  <= cnt_d;
			step_q <= step_d;
			lvl_q  <= lvl_d;
			if (wr.ctrl_we) begin
				vol_q  <= wr.data[3:0];
				duty_q <= wr.data[6:4];
				dc_q   <= wr.data[7];
			end
			if (wr.lo_we) begin
				period_q[7:0] <= wr.data;
			end
			if (wr.hi_we) begin
				period_q[11:8] <= wr.data[3:0];
				en_q           <= wr.data[7];
			end
		end
	end

endmodule

// ----- rtl/core/pss_saw.sv -----
`timescale 1ns / 1ps

module pss_saw (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           tick,
	input  pss_pkg::pss_wr_t               wr,
	input  logic [pss_pkg::ShiftW-1:0]     shift,
	output logic [pss_pkg::SawLvlW-1:0]    level_nxt
);
	import pss_pkg::*;

	logic [PeriodW-1:0] period_q, cnt_q, cnt_d;
	logic [5:0]         rate_q;
	logic               en_q;
	logic [7:0]         acc_q, acc_d;
	logic [3:0]         phase_q, phase_d;
	logic [SawLvlW-1:0] lvl_q, lvl_d;

	always_comb begin
		cnt_d   = cnt_q;
		acc_d   = acc_q;
		phase_d = phase_q;
		lvl_d   = lvl_q;
		if (tick) begin
			if (!en_q) begin
				lvl_d   = '0;
				acc_d   = '0;
				phase_d = '0;
			end else if (cnt_q == '0) begin
				cnt_d = period_q >> shift;
				if (!phase_q[0]) begin
					if (phase_q[3:1] >= 3'd6) begin
						acc_d = '0;
					end else begin
						acc_d = acc_q + {2'b00, rate_q};
					end
				end
				phase_d = (phase_q == SawLastPhase) ? 4'd0 : phase_q + 4'd1;
				lvl_d   = acc_d[7:3];
			end else begin
				cnt_d = cnt_q - 12'd1;
			end
		end
	end

	assign level_nxt = lvl_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			period_q <= '0;
			cnt_q    <= '0;
			rate_q   <= '0;
			en_q     <= 1'b0;
			acc_q    <= '0;
			phase_q  <= '0;
			lvl_q    <= '0;
		end else begin
			cnt_q   <= cnt_d;
			acc_q   <= acc_d;
			phase_q <= phase_d;
			lvl_q   <= lvl_d;
			if (wr.ctrl_we) begin
				rate_q <= wr.data[5:0];
			end
			if (wr.lo_we) begin
				period_q[7:0] <= wr.data;
			end
			if (wr.hi_we) begin
				period_q[11:8] <= wr.data[3:0];
				en_q           <= wr.data[7];
			end
		end
	end

endmodule

// ----- rtl/core/pss_dcblk.sv -----
`timescale 1ns / 1ps

module pss_dcblk (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         mix_valid,
	output logic                         mix_ready,
	input  logic [pss_pkg::MixW-1:0]     mix,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic signed [15:0]           sample
);
	import pss_pkg::*;

	logic              v_s2;
	logic [MixW-1:0]   mix_s2;
	logic [31:0]       dc_q;
	logic              ov_q;
	logic signed [15:0] sample_q;
	logic              adv;

	logic [14:0]        gain_in, gain_s2;
	logic signed [39:0] raw_in, raw_s2, dc_ext, diff, prod, step_q16, dc_sum;
	logic signed [39:0] err, err_q16;
	logic [31:0]        dc_new;
	logic signed [15:0] clamped;

	assign adv       = v_s2 && (!ov_q || out_ready);
	assign mix_ready = !v_s2 || adv;

	// The estimate is Q15.16; both divisions by 65536 truncate toward zero.
	always_comb begin
		gain_in  = 15'(mix) * 15'd500;
		gain_s2  = 15'(mix_s2) * 15'd500;
		raw_in   = {9'b0, gain_in, 16'b0};
		raw_s2   = {9'b0, gain_s2, 16'b0};
		dc_ext   = {{8{dc_q[31]}}, dc_q};
		diff     = raw_in - dc_ext;
		prod     = diff * 40'sd52;
		step_q16 = (prod + (prod[39] ? 40'sd65535 : 40'sd0)) >>> 16;
		dc_sum   = dc_ext + step_q16;
		dc_new   = dc_sum[31:0];
		err      = raw_s2 - dc_ext;
		err_q16  = (err + (err[39] ? 40'sd65535 : 40'sd0)) >>> 16;
		if (err_q16 > 40'sd32767) begin
			clamped = 16'sh7FFF;
		end else if (err_q16 < -40'sd32768) begin
			clamped = 16'sh8000;
		end else begin
			clamped = err_q16[15:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
			dc_q <= '0;
			ov_q <= 1'b0;
		end else begin
			if (mix_valid && mix_ready) begin
				v_s2 <= 1'b1;
				dc_q <= dc_new;
			end else if (adv) begin
				v_s2 <= 1'b0;
			end
			if (adv) begin
				ov_q <= 1'b1;
			end else if (out_ready) begin
				ov_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (mix_valid && mix_ready) begin
			mix_s2 <= mix;
		end
		if (adv) begin
			sample_q <= clamped;
		end
	end

	assign out_valid = ov_q;
	assign sample    = sample_q;

endmodule

// ----- rtl/core/pulse_saw_sound_generator_core.sv -----
`timescale 1ns / 1ps
// Accepts one item per cycle; writes and non-halted ticks update channel state on acceptance.
// A tick that completes a sample period registers its mix at acceptance; the sample then goes
// through the DC estimate register and the output register before out_valid presents it.
// Throughput is one item per cycle, limited only by back pressure on the sample output.
// Async active-low reset loads the sample divider with 40, clears all but mix and sample data.

module pulse_saw_sound_generator_core (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic               req_type,
	input  logic [15:0]        bus_addr,
	input  logic [7:0]         bus_data,
	output logic               out_valid,
	input  logic               out_ready,
	output logic signed [15:0] sample,
	input  logic               cfg_we,
	input  logic [15:0]        cfg_wdata
);
	import pss_pkg::*;

	logic              acc, wr_acc, tick_acc, chan_tick, emit;
	logic [15:0]       maddr;
	pss_wr_t           wr_p0, wr_p1, wr_saw;
	logic              halt_q;
	logic [ShiftW-1:0] shift_q;
	logic [DivW-1:0]   div_q, cnt_q, cnt_inc;
	logic [VolW-1:0]   lvl_p0, lvl_p1;
	logic [SawLvlW-1:0] lvl_saw;
	logic              v_s1, dc_ready;
	logic [MixW-1:0]   mix_s1, mix_d;

	assign acc       = in_valid && in_ready;
	assign wr_acc    = acc && !req_type;
	assign tick_acc  = acc && req_type;
	assign chan_tick = tick_acc && !halt_q;
	assign maddr     = bus_addr & AddrMask;

	always_comb begin
		wr_p0.ctrl_we  = wr_acc && (maddr == AddrP0Ctrl);
		wr_p0.lo_we    = wr_acc && (maddr == AddrP0Lo);
		wr_p0.hi_we    = wr_acc && (maddr == AddrP0Hi);
		wr_p0.data     = bus_data;
		wr_p1.ctrl_we  = wr_acc && (maddr == AddrP1Ctrl);
		wr_p1.lo_we    = wr_acc && (maddr == AddrP1Lo);
		wr_p1.hi_we    = wr_acc && (maddr == AddrP1Hi);
		wr_p1.data     = bus_data;
		wr_saw.ctrl_we = wr_acc && (maddr == AddrSawRate);
		wr_saw.lo_we   = wr_acc && (maddr == AddrSawLo);
		wr_saw.hi_we   = wr_acc && (maddr == AddrSawHi);
		wr_saw.data    = bus_data;
	end

	pss_pulse u_pulse0 (
		.clk       (clk),
		.arst_n    (arst_n),
		.tick      (chan_tick),
		.wr        (wr_p0),
		.shift     (shift_q),
		.level_nxt (lvl_p0)
	);

	pss_pulse u_pulse1 (
		.clk       (clk),
		.arst_n    (arst_n),
		.tick      (chan_tick),
		.wr        (wr_p1),
		.shift     (shift_q),
		.level_nxt (lvl_p1)
	);

	pss_saw u_saw (
		.clk       (clk),
		.arst_n    (arst_n),
		.tick      (chan_tick),
		.wr        (wr_saw),
		.shift     (shift_q),
		.level_nxt (lvl_saw)
	);

	assign cnt_inc = cnt_q + 16'd1;
	assign emit    = (cnt_inc >= div_q);
	assign mix_d   = MixW'(lvl_p0) + MixW'(lvl_p1) + MixW'(lvl_saw);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			halt_q  <= 1'b0;
			shift_q <= '0;
			div_q   <= DividerReset;
			cnt_q   <= '0;
			v_s1    <= 1'b0;
		end else begin
			if (cfg_we) begin
				div_q <= cfg_wdata;
			end
			if (wr_acc && (maddr == AddrHalt)) begin
				halt_q  <= bus_data[0];
				shift_q <= bus_data[2] ? 4'd8 : (bus_data[1] ? 4'd4 : 4'd0);
			end
			if (tick_acc) begin
				cnt_q <= emit ? '0 : cnt_inc;
			end
			if (tick_acc && emit) begin
				v_s1 <= 1'b1;
			end else if (dc_ready) begin
				v_s1 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (tick_acc && emit) begin
			mix_s1 <= mix_d;
		end
	end

	assign in_ready = !v_s1 || dc_ready;

	pss_dcblk u_dcblk (
		.clk       (clk),
		.arst_n    (arst_n),
		.mix_valid (v_s1),
		.mix_ready (dc_ready),
		.mix       (mix_s1),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.sample    (sample)
	);

endmodule
